// ----- hdl/gcnp_pkg.sv -----
package gcnp_pkg;

  localparam int CoordW     = 48;
  localparam int MagW       = CoordW - 1;
  localparam int ExpW       = 4;
  localparam int DigitCntW  = 5;
  localparam int FracCntW   = 3;
  localparam int CfgW       = 3;
  localparam int CfgIdxW    = 2;
  localparam int QueueDepth = 2;

  localparam int DefMaxDigits  = 16;
  localparam int DefValueWidth = 48;

  typedef logic [7:0] byte_t;

  localparam byte_t CharZero  = 8'h30;
  localparam byte_t CharNine  = 8'h39;
  localparam byte_t CharPlus  = 8'h2B;
  localparam byte_t CharMinus = 8'h2D;
  localparam byte_t CharPoint = 8'h2E;
  localparam byte_t CharSpace = 8'h20;
  localparam byte_t CharTab   = 8'h09;
  localparam byte_t CharCr    = 8'h0D;
  localparam byte_t CharLf    = 8'h0A;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusNoDigits = 2'd1;
  localparam logic [1:0] StatusEndEarly = 2'd2;
  localparam logic [1:0] StatusSat      = 2'd3;

  localparam logic [CfgIdxW-1:0] RegIntDigits  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFracDigits = 2'd1;
  localparam logic [CfgIdxW-1:0] RegOmitZeros  = 2'd2;

  localparam logic [2:0] ResetIntDigits  = 3'd4;
  localparam logic [2:0] ResetFracDigits = 3'd6;
  localparam logic       ResetOmitZeros  = 1'b0;

  typedef struct packed {
    logic [2:0] int_digits;
    logic [2:0] frac_digits;
    logic       omit_zeros;
  } cfg_t;

  typedef struct packed {
    logic [MagW-1:0] mag;
    logic [ExpW-1:0] expo;
    logic            neg;
    logic [1:0]      status;
    byte_t           term;
  } job_t;

  // Largest magnitude held: the smaller of the signed range and the digit range.
  function automatic logic [MagW-1:0] mag_limit(input int value_width, input int max_digits);
    int          w;
    int          d;
    logic [63:0] a;
    logic [63:0] b;
    w = value_width;
    d = max_digits;
    if (w > CoordW) w = CoordW;
    if (w < 2) w = 2;
    if (d > 19) d = 19;
    a = (64'd1 << (w - 1)) - 64'd1;
    b = 64'd1;
    for (int i = 0; i < d; i++) begin
      b = b * 64'd10;
    end
    b = b - 64'd1;
    return (a < b) ? a[MagW-1:0] : b[MagW-1:0];
  endfunction

endpackage

// ----- hdl/gcnp_front.sv -----
module gcnp_front #(
  parameter int MAX_DIGITS  = gcnp_pkg::DefMaxDigits,
  parameter int VALUE_WIDTH = gcnp_pkg::DefValueWidth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  gcnp_pkg::cfg_t  cfg_i,
  input  logic            in_valid_i,
  input  gcnp_pkg::byte_t char_i,
  input  logic            eod_i,
  output logic            job_valid_o,
  output gcnp_pkg::job_t  job_o
);
  import gcnp_pkg::*;

  localparam logic [MagW-1:0] Lim = mag_limit(VALUE_WIDTH, MAX_DIGITS);

  typedef enum logic [2:0] {
    PhIdle = 3'b001,
    PhInt  = 3'b010,
    PhFrac = 3'b100
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [MagW-1:0]        acc_q, acc_d;
  logic [DigitCntW-1:0]   dcnt_q, dcnt_d;
  logic [FracCntW-1:0]    fcnt_q, fcnt_d;
  logic                   neg_q, neg_d;
  logic                   sat_q, sat_d;

  logic                   is_digit;
  logic                   is_sign;
  logic                   is_blank;
  logic [3:0]             digit;
  logic [MagW+3:0]        prod;
  logic                   keep;
  logic [ExpW-1:0]        tot;
  logic [ExpW-1:0]        expo;

  always_comb begin
    is_digit = (char_i >= CharZero) && (char_i <= CharNine);
    is_sign  = (char_i == CharPlus) || (char_i == CharMinus);
    is_blank = (char_i == CharSpace) || (char_i == CharTab) ||
               (char_i == CharCr) || (char_i == CharLf);
    digit    = 4'(char_i - CharZero);
    prod     = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + (MagW + 4)'(digit);
    keep     = !sat_q && !((phase_q == PhFrac) && (fcnt_q >= cfg_i.frac_digits));
    tot      = {1'b0, cfg_i.int_digits} + {1'b0, cfg_i.frac_digits};
    if (phase_q == PhFrac) begin
      expo = (fcnt_q <= cfg_i.frac_digits) ? {1'b0, cfg_i.frac_digits - fcnt_q} : '0;
    end else if (cfg_i.omit_zeros && ({1'b0, tot} > dcnt_q)) begin
      expo = ExpW'({1'b0, tot} - dcnt_q);
    end else begin
      expo = '0;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    acc_d       = acc_q;
    dcnt_d      = dcnt_q;
    fcnt_d      = fcnt_q;
    neg_d       = neg_q;
    sat_d       = sat_q;
    job_valid_o = 1'b0;
    job_o       = '0;
    if (in_valid_i) begin
      if (eod_i) begin
        job_valid_o = 1'b1;
        job_o.status = StatusEndEarly;
      end else if (is_digit) begin
        if (dcnt_q != '1) begin
          dcnt_d = dcnt_q + 1'b1;
        end
        if (keep) begin
          if (prod > (MagW + 4)'(Lim)) begin
            acc_d = Lim;
            sat_d = 1'b1;
          end else begin
            acc_d = prod[MagW-1:0];
          end
          if (phase_q == PhFrac) begin
            fcnt_d = fcnt_q + 1'b1;
          end
        end
        if (phase_q != PhFrac) begin
          phase_d = PhInt;
        end
      end else if ((char_i == CharPoint) && (phase_q != PhFrac)) begin
        phase_d = PhFrac;
      end else if ((phase_q != PhInt) && (phase_q != PhFrac) && is_sign) begin
        neg_d   = (char_i == CharMinus);
        phase_d = PhInt;
      end else if ((phase_q != PhInt) && (phase_q != PhFrac) && is_blank) begin
        phase_d = PhIdle;
      end else begin
        job_valid_o = 1'b1;
        job_o.term  = char_i;
        if (dcnt_q == '0) begin
          job_o.status = StatusNoDigits;
        end else begin
          job_o.mag    = acc_q;
          job_o.neg    = neg_q;
          job_o.expo   = sat_q ? '0 : expo;
          job_o.status = sat_q ? StatusSat : StatusOk;
        end
      end
      if (job_valid_o) begin
        phase_d = PhIdle;
        acc_d   = '0;
        dcnt_d  = '0;
        fcnt_d  = '0;
        neg_d   = 1'b0;
        sat_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      acc_q   <= '0;
      dcnt_q  <= '0;
      fcnt_q  <= '0;
      neg_q   <= 1'b0;
      sat_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      dcnt_q  <= dcnt_d;
      fcnt_q  <= fcnt_d;
      neg_q   <= neg_d;
      sat_q   <= sat_d;
    end
  end

endmodule

// ----- hdl/gcnp_queue.sv -----
module gcnp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  gcnp_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output gcnp_pkg::job_t data_o
);
  import gcnp_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  always_comb begin
    full_o   = (cnt_q == CntW'(QueueDepth));
    empty_o  = (cnt_q == '0);
    do_push  = push_i && !full_o;
    do_pop   = pop_i && !empty_o;
    data_o   = mem_q[rd_ptr_q];
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ----- hdl/gcnp_back.sv -----
module gcnp_back #(
  parameter int MAX_DIGITS  = gcnp_pkg::DefMaxDigits,
  parameter int VALUE_WIDTH = gcnp_pkg::DefValueWidth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               job_empty_i,
  input  gcnp_pkg::job_t                     job_i,
  output logic                               job_pop_o,
  output logic                               out_empty_o,
  input  logic                               out_pop_i,
  output logic signed [gcnp_pkg::CoordW-1:0] value_o,
  output logic [1:0]                         status_o,
  output gcnp_pkg::byte_t                    term_o
);
  import gcnp_pkg::*;

  localparam logic [MagW-1:0] Lim      = mag_limit(VALUE_WIDTH, MAX_DIGITS);
  localparam logic [MagW-1:0] LimDiv10 = Lim / 10;

  typedef enum logic [1:0] {
    BkIdle  = 2'b01,
    BkScale = 2'b10
  } back_state_e;

  back_state_e              state_q, state_d;
  logic [MagW-1:0]          m_q, m_d;
  logic [ExpW-1:0]          expo_q, expo_d;
  logic                     neg_q, neg_d;
  logic [1:0]               status_q, status_d;
  byte_t                    term_q, term_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [CoordW-1:0] value_q, value_d;
  logic [1:0]               out_status_q, out_status_d;
  byte_t                    out_term_q, out_term_d;

  logic                     finish;
  logic [MagW+2:0]          times10;
  logic [CoordW-1:0]        mag_ext;

  always_comb begin
    times10   = {m_q, 3'b0} + {2'b0, m_q, 1'b0};
    mag_ext   = {1'b0, m_q};
    finish    = (state_q == BkScale) && (expo_q == '0) && (!out_valid_q || out_pop_i);
    job_pop_o = (state_q == BkIdle) && !job_empty_i;

    state_d      = state_q;
    m_d          = m_q;
    expo_d       = expo_q;
    neg_d        = neg_q;
    status_d     = status_q;
    term_d       = term_q;
    out_valid_d  = out_valid_q;
    value_d      = value_q;
    out_status_d = out_status_q;
    out_term_d   = out_term_q;

    unique case (state_q)
      BkIdle: begin
        if (job_pop_o) begin
          m_d      = job_i.mag;
          expo_d   = job_i.expo;
          neg_d    = job_i.neg;
          status_d = job_i.status;
          term_d   = job_i.term;
          state_d  = BkScale;
        end
      end
      BkScale: begin
        if (expo_q != '0) begin
          if (m_q > LimDiv10) begin
            m_d      = Lim;
            expo_d   = '0;
            status_d = StatusSat;
          end else begin
            m_d    = times10[MagW-1:0];
            expo_d = expo_q - 1'b1;
          end
        end else if (finish) begin
          state_d = BkIdle;
        end
      end
      default: state_d = BkIdle;
    endcase

    if (finish) begin
      out_valid_d  = 1'b1;
      value_d      = neg_q ? -mag_ext : mag_ext;
      out_status_d = status_q;
      out_term_d   = term_q;
    end else if (out_pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q          <= m_d;
    expo_q       <= expo_d;
    neg_q        <= neg_d;
    status_q     <= status_d;
    term_q       <= term_d;
    value_q      <= value_d;
    out_status_q <= out_status_d;
    out_term_q   <= out_term_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_empty_o = !out_valid_q;
  assign value_o     = value_q;
  assign status_o    = out_status_q;
  assign term_o      = out_term_q;

endmodule

// ----- hdl/gerber_coordinate_number_parser.sv -----
// Channel   Direction  Handshake                 Word
// input     in         push / full               char_in_i, end_of_data_i
// result    out        empty / pop               coord_value_o, parse_status_o, terminator_o
// config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A byte is taken every cycle while full is low; digits are folded into the magnitude
// at once. A number's end goes through a two-word queue to the scaler, which multiplies
// by ten once per power of ten of padding (none to fourteen) and then registers the
// result for the output. Reset clears the parse state and sets the format to four
// integer and six fraction digits. A held result stalls the scaler, and a full queue
// raises full.
module gerber_coordinate_number_parser #(
  parameter int MAX_DIGITS  = gcnp_pkg::DefMaxDigits,
  parameter int VALUE_WIDTH = gcnp_pkg::DefValueWidth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic [7:0]                          char_in_i,
  input  logic                                end_of_data_i,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [gcnp_pkg::CoordW-1:0]  coord_value_o,
  output logic [1:0]                          parse_status_o,
  output logic [7:0]                          terminator_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gcnp_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [gcnp_pkg::CfgW-1:0]           cfg_data_i
);
  import gcnp_pkg::*;

  cfg_t  cfg_q, cfg_d;
  logic  in_take;
  logic  job_valid;
  job_t  job_in;
  logic  job_empty;
  logic  job_pop;
  job_t  job_out;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegIntDigits:  cfg_d.int_digits  = cfg_data_i[2:0];
        RegFracDigits: cfg_d.frac_digits = cfg_data_i[2:0];
        RegOmitZeros:  cfg_d.omit_zeros  = cfg_data_i[0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.int_digits  <= ResetIntDigits;
      cfg_q.frac_digits <= ResetFracDigits;
      cfg_q.omit_zeros  <= ResetOmitZeros;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_take = push && !full;

  gcnp_front #(
    .MAX_DIGITS  (MAX_DIGITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_take),
    .char_i      (char_in_i),
    .eod_i       (end_of_data_i),
    .job_valid_o (job_valid),
    .job_o       (job_in)
  );

  gcnp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .data_o  (job_out)
  );

  gcnp_back #(
    .MAX_DIGITS  (MAX_DIGITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .out_empty_o (empty),
    .out_pop_i   (pop),
    .value_o     (coord_value_o),
    .status_o    (parse_status_o),
    .term_o      (terminator_o)
  );

endmodule

// ----- sim/tb_gerber_coordinate_number_parser.sv -----
module tb_gerber_coordinate_number_parser;
  import gcnp_pkg::*;

  localparam int MaxDigits  = 16;
  localparam int ValueWidth = 48;
  localparam logic [63:0] SignedMax = (64'd1 << (ValueWidth - 1)) - 64'd1;
  localparam logic [63:0] DigitMax  = 64'd9999999999999999;
  localparam logic [63:0] MagLimit  = (SignedMax < DigitMax) ? SignedMax : DigitMax;
  localparam int CycleLimit = 600000;
  localparam int DrainCycles = 24;

  typedef enum logic [1:0] {ScanIdle, ScanInt, ScanFrac} scan_phase_e;

  typedef struct {
    logic signed [CoordW-1:0] coord;
    logic [1:0]               status;
    byte_t                    term;
  } coord_word_t;

  class coord_checker;
    int unsigned int_digits;
    int unsigned frac_digits;
    bit          omit_zeros;
    logic [63:0] mant;
    int unsigned ndigits;
    int unsigned nfrac;
    bit          neg;
    bit          sat;
    scan_phase_e phase;
    coord_word_t pending_coords[$];
    int          bytes_in;
    int          words_checked;
    int          errors;
    int          status_seen[4];

    function new();
      int_digits  = ResetIntDigits;
      frac_digits = ResetFracDigits;
      omit_zeros  = ResetOmitZeros;
      bytes_in = 0;
      words_checked = 0;
      errors = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      restart();
    endfunction

    function void restart();
      mant = 64'd0;
      ndigits = 0;
      nfrac = 0;
      neg = 1'b0;
      sat = 1'b0;
      phase = ScanIdle;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        RegIntDigits:  int_digits = data;
        RegFracDigits: frac_digits = data;
        RegOmitZeros:  omit_zeros = data[0];
        default: ;
      endcase
    endfunction

    function bit parser_idle();
      return phase == ScanIdle;
    endfunction

    // Works out the word, if any, that an accepted input byte brings about.
    function void take_byte(byte_t c, bit eod);
      coord_word_t w;
      logic [63:0] d;
      logic [63:0] mag;
      int unsigned e;
      int unsigned total;
      int unsigned i;
      bytes_in++;
      if (eod) begin
        w.coord = '0;
        w.status = StatusEndEarly;
        w.term = 8'h00;
        pending_coords.insert(pending_coords.size(), w);
        restart();
        return;
      end
      if (c >= CharZero && c <= CharNine) begin
        d = 64'(c - CharZero);
        if (ndigits < 31) ndigits++;
        if (!sat && !(phase == ScanFrac && nfrac >= frac_digits)) begin
          if (mant > (MagLimit - d) / 64'd10) begin
            mant = MagLimit;
            sat = 1'b1;
          end else begin
            mant = mant * 64'd10 + d;
          end
          if (phase == ScanFrac) nfrac = (nfrac + 1) & 7;
        end
        if (phase == ScanIdle) phase = ScanInt;
        return;
      end
      if (c == CharPoint && phase != ScanFrac) begin
        phase = ScanFrac;
        return;
      end
      if (phase == ScanIdle && (c == CharPlus || c == CharMinus)) begin
        neg = (c == CharMinus);
        phase = ScanInt;
        return;
      end
      if (phase == ScanIdle &&
          (c == CharSpace || c == CharTab || c == CharCr || c == CharLf)) begin
        return;
      end
      if (ndigits == 0) begin
        w.coord = '0;
        w.status = StatusNoDigits;
      end else begin
        if (phase == ScanFrac) begin
          e = (nfrac <= frac_digits) ? frac_digits - nfrac : 0;
        end else if (omit_zeros) begin
          total = int_digits + frac_digits;
          e = (total > ndigits) ? total - ndigits : 0;
        end else begin
          e = 0;
        end
        mag = mant;
        if (!sat) begin
          for (i = 0; i < e; i++) begin
            if (mag > MagLimit / 64'd10) begin
              mag = MagLimit;
              sat = 1'b1;
              break;
            end
            mag = mag * 64'd10;
          end
        end
        w.status = sat ? StatusSat : StatusOk;
        w.coord = mag[CoordW-1:0];
        if (neg) w.coord = -w.coord;
      end
      w.term = c;
      pending_coords.insert(pending_coords.size(), w);
      restart();
    endfunction

    function void check_word(logic signed [CoordW-1:0] coord, logic [1:0] status,
                             byte_t term);
      coord_word_t w;
      words_checked++;
      status_seen[status]++;
      if (pending_coords.size() == 0) begin
        $error("result word %0d arrived with no number pending", words_checked);
        errors++;
        return;
      end
      w = pending_coords.pop_front();
      if (coord !== w.coord) begin
        $error("coord_value: expected %0d, actual %0d", w.coord, coord);
        errors++;
      end
      if (status !== w.status) begin
        $error("parse_status: expected %0d, actual %0d", w.status, status);
        errors++;
      end
      if (term !== w.term) begin
        $error("terminator: expected 0x%02h, actual 0x%02h", w.term, term);
        errors++;
      end
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       push = 1'b0;
  logic                       full;
  logic [7:0]                 char_in_i = 8'h00;
  logic                       end_of_data_i = 1'b0;
  logic                       empty;
  logic                       pop = 1'b0;
  logic signed [CoordW-1:0]   coord_value_o;
  logic [1:0]                 parse_status_o;
  logic [7:0]                 terminator_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CfgIdxW-1:0]         cfg_index_i = '0;
  logic [CfgW-1:0]            cfg_data_i = '0;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          cycle_count = 0;
  coord_checker coord_sb = new();

  gerber_coordinate_number_parser #(
    .MAX_DIGITS (MaxDigits),
    .VALUE_WIDTH(ValueWidth)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .char_in_i     (char_in_i),
    .end_of_data_i (end_of_data_i),
    .empty         (empty),
    .pop           (pop),
    .coord_value_o (coord_value_o),
    .parse_status_o(parse_status_o),
    .terminator_o  (terminator_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      pop = rst_ni && ($urandom_range(99) >= recv_idle_pct);
      @(posedge clk_i);
      if (pop && !empty) begin
        coord_sb.check_word(coord_value_o, parse_status_o, terminator_o);
      end
    end
  end

  task automatic send_byte(byte_t c, bit eod);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push = 1'b1;
    char_in_i = c;
    end_of_data_i = eod;
    do @(posedge clk_i); while (full);
    coord_sb.take_byte(c, eod);
  endtask

  task automatic send_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(byte_t'(s[i]), 1'b0);
  endtask

  function automatic byte_t pick_blank();
    case ($urandom_range(3))
      0: return CharSpace;
      1: return CharTab;
      2: return CharCr;
      default: return CharLf;
    endcase
  endfunction

  function automatic byte_t pick_end();
    case ($urandom_range(5))
      0: return "X";
      1: return "Y";
      2: return "I";
      3: return "J";
      4: return "D";
      default: return "*";
    endcase
  endfunction

  // Mostly well-formed coordinates with random content, ended in varied ways.
  task automatic send_number();
    int nblank;
    int nint;
    int nfrac;
    int pick;
    int i;
    nblank = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
    for (i = 0; i < nblank; i++) send_byte(pick_blank(), 1'b0);
    pick = $urandom_range(2);
    if (pick == 1) send_byte(CharPlus, 1'b0);
    else if (pick == 2) send_byte(CharMinus, 1'b0);
    nint = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 8);
    for (i = 0; i < nint; i++) send_byte(byte_t'(CharZero + $urandom_range(9)), 1'b0);
    if ($urandom_range(2) == 0) begin
      send_byte(CharPoint, 1'b0);
      nfrac = $urandom_range(0, 9);
      for (i = 0; i < nfrac; i++) send_byte(byte_t'(CharZero + $urandom_range(9)), 1'b0);
    end
    pick = $urandom_range(19);
    if (pick == 0) begin
      send_byte(byte_t'($urandom_range(255)), 1'b1);
    end else if (pick < 4) begin
      send_byte(byte_t'($urandom_range(255)), 1'b0);
    end else if (pick < 7) begin
      case ($urandom_range(3))
        0: send_byte(CharPlus, 1'b0);
        1: send_byte(CharMinus, 1'b0);
        2: send_byte(CharPoint, 1'b0);
        default: send_byte(pick_blank(), 1'b0);
      endcase
    end else begin
      send_byte(pick_end(), 1'b0);
    end
  endtask

  task automatic send_noise();
    int n;
    int i;
    n = $urandom_range(1, 4);
    for (i = 0; i < n; i++) begin
      send_byte(byte_t'($urandom_range(255)), $urandom_range(15) == 0);
    end
  endtask

  task automatic settle();
    if (!coord_sb.parser_idle()) send_byte("*", 1'b0);
    @(negedge clk_i);
    push = 1'b0;
    while (coord_sb.pending_coords.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    coord_sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    int ph;
    int k;
    int fmt_int;
    int fmt_frac;
    int fmt_omit;
    int target;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // The directed part runs at the reset format of four integer and six fraction digits.
    send_idle_pct = 9;
    recv_idle_pct = 80;
    send_byte(8'h00, 1'b0);
    send_text("-.Y");
    send_byte(CharSpace, 1'b0);
    send_byte(CharTab, 1'b0);
    send_byte(CharCr, 1'b0);
    send_byte(CharLf, 1'b0);
    send_text("-12 ");
    send_text("1.2.");
    send_text("+-");
    send_text("45");
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    send_text("999999999.");
    send_byte(8'hFF, 1'b0);

    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 80 : 0;
      recv_idle_pct = (ph == 0) ? 80 : (ph == 1) ? 9 : 0;
      for (k = 0; k < 2; k++) begin
        case (ph * 2 + k)
          0: begin fmt_int = 0; fmt_frac = 0; fmt_omit = 0; end
          1: begin fmt_int = 7; fmt_frac = 7; fmt_omit = 1; end
          2: begin fmt_int = 7; fmt_frac = 0; fmt_omit = 1; end
          3: begin fmt_int = 0; fmt_frac = 7; fmt_omit = 0; end
          4: begin fmt_int = 3; fmt_frac = 2; fmt_omit = 1; end
          default: begin
            fmt_int = $urandom_range(7);
            fmt_frac = $urandom_range(7);
            fmt_omit = $urandom_range(1);
          end
        endcase
        settle();
        write_reg(RegIntDigits, CfgW'(fmt_int));
        write_reg(RegFracDigits, CfgW'(fmt_frac));
        write_reg(RegOmitZeros, CfgW'(fmt_omit));
        target = coord_sb.bytes_in + 285;
        while (coord_sb.bytes_in < target) begin
          if ($urandom_range(9) == 0) send_noise();
          else send_number();
        end
      end
    end
    settle();

    $display("Checked %0d result words from %0d input words over seven formats.",
             coord_sb.words_checked, coord_sb.bytes_in);
    $display("Status mix: %0d ok, %0d no digits, %0d ended early, %0d saturated.",
             coord_sb.status_seen[StatusOk], coord_sb.status_seen[StatusNoDigits],
             coord_sb.status_seen[StatusEndEarly], coord_sb.status_seen[StatusSat]);
    if (coord_sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- gerber_coordinate_number_parser.f -----
hdl/gcnp_pkg.sv
hdl/gcnp_front.sv
hdl/gcnp_queue.sv
hdl/gcnp_back.sv
hdl/gerber_coordinate_number_parser.sv
sim/tb_gerber_coordinate_number_parser.sv
